FILE: hw/rtl/smd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smd_pkg
// Shared constants and types of the spectrum max-hold decimator.
// ----------------------------------------------------------------------------
package smd_pkg;

   localparam int MAX_BINS  = 16384;
   localparam int MAX_GROUP = 64;

   localparam int BIN_W = $clog2(MAX_BINS + 1);
   localparam int GRP_W = $clog2(MAX_GROUP + 1);

   localparam logic [31:0] MAGIC_WORD = 32'h7743FA9F;

   // configuration register indexes
   localparam logic [1:0] CSR_WINDOW_START = 2'd0;
   localparam logic [1:0] CSR_WINDOW_END   = 2'd1;
   localparam logic [1:0] CSR_GROUP_SIZE   = 2'd2;
   localparam logic [1:0] CSR_STREAM_ID    = 2'd3;

   localparam logic [13:0] RESET_WINDOW_START = 14'd2250;
   localparam logic [14:0] RESET_WINDOW_END   = 15'd7750;
   localparam logic [6:0]  RESET_GROUP_SIZE   = 7'd10;
   localparam logic [7:0]  RESET_STREAM_ID    = 8'd1;

   // byte positions within one group's packet piece
   localparam logic [2:0] POS_MAGIC3 = 3'd0;
   localparam logic [2:0] POS_MAGIC2 = 3'd1;
   localparam logic [2:0] POS_MAGIC1 = 3'd2;
   localparam logic [2:0] POS_MAGIC0 = 3'd3;
   localparam logic [2:0] POS_ID     = 3'd4;
   localparam logic [2:0] POS_HI     = 3'd5;
   localparam logic [2:0] POS_LO     = 3'd6;

   typedef struct packed {
      logic [13:0] window_start;
      logic [14:0] window_end;
      logic [6:0]  group_size;
      logic [7:0]  stream_id;
   } cfg_type;

   // one finished group waiting to be sent
   typedef struct packed {
      logic        header;
      logic        last;
      logic [15:0] max_value;
   } group_type;

endpackage
`default_nettype wire

FILE: hw/rtl/spectrum_max_decimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_max_decimator
// Max-hold decimator turning FFT magnitude bins into a byte packet per frame.
// ----------------------------------------------------------------------------
// Bins are numbered from zero after each frame_start beat; bins inside
// [window_start, window_end) are merged by maximum in groups of group_size and
// each full group leaves as two bytes, high first, the frame's first group led
// by the magic word and stream id. One bin beat is taken per cycle while the
// one-group holding register is free; the byte serializer sends one beat a
// cycle while the receiver is ready, so a group leaves as two bytes (seven
// with the header) while the following group can build up meanwhile.
// A finished group is registered in the holding register, then in the serializer.
module spectrum_max_decimator
   import smd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // bin beats
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] bin_value
   input  wire logic        req_tuser,   // [0] frame_start
   // packet bytes
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_data
);

   cfg_type   cfg_ff, cfg_in;
   group_type slot;
   logic      slot_valid, load;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_START: cfg_in.window_start = csr_data[13:0];
            CSR_WINDOW_END:   cfg_in.window_end   = csr_data;
            CSR_GROUP_SIZE:   cfg_in.group_size   = csr_data[6:0];
            CSR_STREAM_ID:    cfg_in.stream_id    = csr_data[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_start <= RESET_WINDOW_START;
         cfg_ff.window_end   <= RESET_WINDOW_END;
         cfg_ff.group_size   <= RESET_GROUP_SIZE;
         cfg_ff.stream_id    <= RESET_STREAM_ID;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smd_group u_group (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .bin_value   (req_tdata),
      .frame_start (req_tuser),
      .load        (load),
      .slot        (slot),
      .slot_valid  (slot_valid)
   );

   smd_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .slot       (slot),
      .slot_valid (slot_valid),
      .stream_id  (cfg_ff.stream_id),
      .load       (load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/smd_group.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smd_group
// Bin numbering, window test and max-hold grouping; holds one finished group.
// ----------------------------------------------------------------------------
module smd_group
   import smd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] bin_value,
   input  wire logic        frame_start,
   input  wire logic        load,
   output group_type        slot,
   output logic             slot_valid
);

   logic [BIN_W-1:0] bin_index_ff, bin_index_in;
   logic [GRP_W-1:0] group_fill_ff, group_fill_in;
   logic [15:0]      running_max_ff, running_max_in;
   logic             header_sent_ff, header_sent_in;
   logic             slot_valid_ff, slot_valid_in;
   group_type        slot_ff, slot_in;

   logic [BIN_W-1:0] idx, end_eff, remaining;
   logic [GRP_W-1:0] fill, fill_next, gs_eff;
   logic [15:0]      max_cur, max_next;
   logic             hs, in_window, done, accept;

   assign req_ready  = !slot_valid_ff || load;
   assign accept     = req_valid && req_ready;
   assign slot       = slot_ff;
   assign slot_valid = slot_valid_ff;

   always_comb begin
      idx     = frame_start ? '0 : bin_index_ff;
      fill    = frame_start ? '0 : group_fill_ff;
      max_cur = frame_start ? '0 : running_max_ff;
      hs      = frame_start ? 1'b0 : header_sent_ff;

      if ((BIN_W + 1)'(cfg.window_end) > (BIN_W + 1)'(MAX_BINS)) begin
         end_eff = BIN_W'(MAX_BINS);
      end else begin
         end_eff = BIN_W'(cfg.window_end);
      end

      if (cfg.group_size == '0) begin
         gs_eff = GRP_W'(1);
      end else if ((GRP_W + 8)'(cfg.group_size) > (GRP_W + 8)'(MAX_GROUP)) begin
         gs_eff = GRP_W'(MAX_GROUP);
      end else begin
         gs_eff = GRP_W'(cfg.group_size);
      end

      in_window = (idx < BIN_W'(MAX_BINS)) && (idx >= BIN_W'(cfg.window_start))
                  && (idx < end_eff);
      max_next  = (bin_value > max_cur) ? bin_value : max_cur;
      fill_next = fill + GRP_W'(1);
      done      = in_window && (fill_next >= gs_eff);
      // bins left in the window after this one
      remaining = end_eff - idx - BIN_W'(1);
   end

   always_comb begin
      bin_index_in   = bin_index_ff;
      group_fill_in  = group_fill_ff;
      running_max_in = running_max_ff;
      header_sent_in = header_sent_ff;
      slot_valid_in  = slot_valid_ff && !load;
      slot_in        = slot_ff;
      if (accept) begin
         bin_index_in   = (idx < BIN_W'(MAX_BINS)) ? idx + BIN_W'(1) : idx;
         group_fill_in  = fill;
         running_max_in = max_cur;
         header_sent_in = hs;
         if (done) begin
            group_fill_in     = '0;
            running_max_in    = '0;
            header_sent_in    = 1'b1;
            slot_valid_in     = 1'b1;
            slot_in.header    = !hs;
            slot_in.last      = remaining < BIN_W'(gs_eff);
            slot_in.max_value = max_next;
         end else if (in_window) begin
            group_fill_in  = fill_next;
            running_max_in = max_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_index_ff   <= '0;
         group_fill_ff  <= '0;
         running_max_ff <= '0;
         header_sent_ff <= 1'b0;
         slot_valid_ff  <= 1'b0;
      end else begin
         bin_index_ff   <= bin_index_in;
         group_fill_ff  <= group_fill_in;
         running_max_ff <= running_max_in;
         header_sent_ff <= header_sent_in;
         slot_valid_ff  <= slot_valid_in;
      end
      slot_ff <= slot_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/smd_serial.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smd_serial
// Turns a finished group into its header and value bytes, one beat a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module smd_serial
   import smd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire group_type   slot,
   input  wire logic        slot_valid,
   input  wire logic [7:0]  stream_id,
   output logic             load,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   logic        busy_ff, busy_in;
   logic [2:0]  pos_ff, pos_in;
   group_type   cur_ff, cur_in;
   logic        fire, finish;

   assign fire       = busy_ff && rsp_tready;
   assign finish     = fire && (pos_ff == POS_LO);
   assign load       = slot_valid && (!busy_ff || finish);
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = (pos_ff == POS_LO) && cur_ff.last;

   always_comb begin
      case (pos_ff)
         POS_MAGIC3: rsp_tdata = MAGIC_WORD[31:24];
         POS_MAGIC2: rsp_tdata = MAGIC_WORD[23:16];
         POS_MAGIC1: rsp_tdata = MAGIC_WORD[15:8];
         POS_MAGIC0: rsp_tdata = MAGIC_WORD[7:0];
         POS_ID:     rsp_tdata = stream_id;
         POS_HI:     rsp_tdata = cur_ff.max_value[15:8];
         POS_LO:     rsp_tdata = cur_ff.max_value[7:0];
         default:    rsp_tdata = '0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      cur_in  = cur_ff;
      if (load) begin
         busy_in = 1'b1;
         cur_in  = slot;
         // groups after the first of a frame skip the header
         pos_in  = slot.header ? POS_MAGIC3 : POS_HI;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (fire) begin
         pos_in = pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= POS_MAGIC3;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
      cur_ff <= cur_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/smd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks of the spectrum max-hold decimator, bound to the top.
// ----------------------------------------------------------------------------
module smd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        csr_ready
);

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat offered right after reset");

   // a stalled byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // an idle serializer never leaves the input stalled
   a_no_deadlock: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no output pending");

   // register writes never stall, not even while bytes are pending
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> csr_ready)
      else $error("register port stalled");

endmodule

bind spectrum_max_decimator smd_checker u_smd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);
`default_nettype wire

FILE: verif/spectrum_max_decimator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_max_decimator_tb
// Self-checking bench for the max-hold spectrum decimator.
// ----------------------------------------------------------------------------
// Streams bin beats into the block and predicts every packet byte (header,
// high and low bytes of each group maximum, last flag) from a behavioral copy
// of the windowing and grouping rules. Directed tests cover reset defaults,
// window and group-size corners, dropped partial groups, mid-frame register
// changes, out-of-range window registers and one long receiver hold-off;
// random frames follow under three idling patterns.
module spectrum_max_decimator_tb;
   import smd_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 7;
   localparam int SETTLE       = 10;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } pkt_byte_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [14:0] csr_data = '0;

   // behavioral copy of the decimator
   logic [13:0] win_start = RESET_WINDOW_START;
   logic [14:0] win_end   = RESET_WINDOW_END;
   logic [6:0]  grp_size  = RESET_GROUP_SIZE;
   logic [7:0]  strm_id   = RESET_STREAM_ID;
   int          bin_idx   = 0;
   int          grp_fill  = 0;
   logic [15:0] grp_max   = '0;
   bit          hdr_sent  = 1'b0;

   pkt_byte_t   pkt_q[$];
   int          bins_taken = 0;
   int          errors = 0;
   int          cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          stall_len = 0;

   spectrum_max_decimator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d packet bytes outstanding", $time, pkt_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void load_register(logic [1:0] idx, logic [14:0] value);
      case (idx)
         CSR_WINDOW_START: win_start = value[13:0];
         CSR_WINDOW_END:   win_end   = value;
         CSR_GROUP_SIZE:   grp_size  = value[6:0];
         CSR_STREAM_ID:    strm_id   = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic void push_byte(logic [7:0] data, logic last);
      pkt_byte_t b;
      b.data = data;
      b.last = last;
      pkt_q.push_back(b);
   endfunction

   // expected packet bytes caused by one bin beat
   function automatic void decimate_bin(logic [15:0] value, logic frame_start);
      int idx;
      int end_eff;
      int gs;
      int remaining;
      if (frame_start) begin
         bin_idx  = 0;
         grp_fill = 0;
         grp_max  = '0;
         hdr_sent = 1'b0;
      end
      idx = bin_idx;
      if (bin_idx < MAX_BINS)
         bin_idx++;
      end_eff = (int'(win_end) > MAX_BINS) ? MAX_BINS : int'(win_end);
      gs = int'(grp_size);
      if (gs == 0)
         gs = 1;
      if (gs > MAX_GROUP)
         gs = MAX_GROUP;
      if (idx >= MAX_BINS || idx < int'(win_start) || idx >= end_eff)
         return;
      bins_taken++;
      if (value > grp_max)
         grp_max = value;
      grp_fill++;
      if (grp_fill >= gs) begin
         remaining = end_eff - (idx + 1);
         if (!hdr_sent) begin
            push_byte(MAGIC_WORD[31:24], 1'b0);
            push_byte(MAGIC_WORD[23:16], 1'b0);
            push_byte(MAGIC_WORD[15:8], 1'b0);
            push_byte(MAGIC_WORD[7:0], 1'b0);
            push_byte(strm_id, 1'b0);
            hdr_sent = 1'b1;
         end
         push_byte(grp_max[15:8], 1'b0);
         push_byte(grp_max[7:0], remaining < gs);
         grp_fill = 0;
         grp_max  = '0;
      end
   endfunction

   // register writes and bin beats update the prediction, packet bytes are checked
   always @(posedge clock) begin
      pkt_byte_t exp_b;
      if (!reset) begin
         if (csr_valid && csr_ready)
            load_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            decimate_bin(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (pkt_q.size() == 0) begin
               $display("%0t unexpected packet byte: expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               exp_b = pkt_q.pop_front();
               if (rsp_tdata !== exp_b.data) begin
                  $display("%0t out_byte mismatch: expected %h, actual %h",
                           $time, exp_b.data, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== exp_b.last) begin
                  $display("%0t packet_last mismatch: expected %b, actual %b",
                           $time, exp_b.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (stall_len != 0) begin
            hold = stall_len;
            stall_len = 0;
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic logic [15:0] rand_bin();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h1 << $urandom_range(0, 15);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_bin(input logic [15:0] value, input logic frame_start);
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= frame_start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // stop sending and wait until every predicted byte has left the block
   task automatic drain_packets();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pkt_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [14:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_window(input logic [14:0] ws, input logic [14:0] we,
                             input logic [14:0] gs, input logic [14:0] id);
      drain_packets();
      csr_write(CSR_WINDOW_START, ws);
      csr_write(CSR_WINDOW_END, we);
      csr_write(CSR_GROUP_SIZE, gs);
      csr_write(CSR_STREAM_ID, id);
   endtask

   // reset values, bins numbered from zero without any frame mark
   task automatic test_reset_defaults();
      int i;
      for (i = 0; i < 6; i++)
         send_bin(rand_bin(), 1'b0);
      drain_packets();
      // open the window from zero, group size and stream id keep their reset values
      csr_write(CSR_WINDOW_START, 15'd0);
      for (i = 0; i < 12; i++)
         send_bin(rand_bin(), 1'b0);
      drain_packets();
   endtask

   task automatic test_window_and_groups();
      logic [15:0] vals [9] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8000, 16'h00FF,
                                16'h0001, 16'h7FFF, 16'hFF00, 16'hAAAA};
      int i;
      set_window(15'd2, 15'd8, 15'd3, 15'h00A5);
      for (i = 0; i < 9; i++)
         send_bin(vals[i], i == 0);
      drain_packets();
   endtask

   // group size zero acts as one, above the maximum acts as the maximum
   task automatic test_group_extremes();
      int i;
      set_window(15'd0, 15'd3, 15'd0, 15'h0000);
      for (i = 0; i < 4; i++)
         send_bin(rand_bin(), i == 0);
      set_window(15'd0, 15'd64, 15'd127, 15'h00FF);
      for (i = 0; i < 66; i++)
         send_bin(rand_bin(), i == 0);
      drain_packets();
   endtask

   task automatic test_empty_window();
      int i;
      set_window(15'd16383, 15'd100, 15'd1, 15'h005A);
      for (i = 0; i < 3; i++)
         send_bin(rand_bin(), i == 0);
      set_window(15'd0, 15'd0, 15'd1, 15'h005A);
      for (i = 0; i < 3; i++)
         send_bin(rand_bin(), i == 0);
      drain_packets();
   endtask

   // partial group at window end is dropped, next frame restarts with a header
   task automatic test_partial_group();
      int i;
      set_window(15'd0, 15'd7, 15'd3, 15'h0033);
      for (i = 0; i < 8; i++)
         send_bin(rand_bin(), i == 0);
      for (i = 0; i < 3; i++)
         send_bin(rand_bin(), i == 0);
      drain_packets();
   endtask

   // shrinking the group size mid-frame completes the open group on its next bin
   task automatic test_mid_frame_change();
      int i;
      set_window(15'd0, 15'd40, 15'd8, 15'h0042);
      for (i = 0; i < 5; i++)
         send_bin(rand_bin(), i == 0);
      drain_packets();
      csr_write(CSR_GROUP_SIZE, 15'd3);
      csr_write(CSR_STREAM_ID, 15'h7F81);
      for (i = 0; i < 7; i++)
         send_bin(rand_bin(), 1'b0);
      drain_packets();
   endtask

   // window start cut to its field width, window end clipped to the bin limit
   task automatic test_long_frame();
      int i;
      set_window(15'h4001, 15'h7FFF, 15'd4, 15'h00FF);
      for (i = 0; i < 10; i++)
         send_bin(rand_bin(), i == 0);
      drain_packets();
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_backpressure();
      int i;
      set_window(15'd0, 15'd200, 15'd1, 15'h0011);
      stall_len = 400;
      for (i = 0; i < 16; i++)
         send_bin(rand_bin(), i == 0);
      drain_packets();
   endtask

   task automatic test_random_frames(input int target);
      int sent;
      int n;
      int cut;
      int i;
      bit mark_first;
      logic [14:0] ws;
      logic [14:0] we;
      logic [6:0] gs;
      sent = 0;
      while (sent < target) begin
         ws = 15'($urandom_range(0, 8));
         we = ws + 15'($urandom_range(0, 24));
         if ($urandom_range(0, 7) == 0)
            we = 15'($urandom_range(MAX_BINS, 32767));
         if ($urandom_range(0, 7) == 0)
            gs = 7'($urandom_range(0, 127));
         else
            gs = 7'($urandom_range(1, 8));
         set_window(ws, we, {8'($urandom_range(0, 255)), gs},
                    15'($urandom_range(0, 32767)));
         if (we > MAX_BINS)
            n = ws + $urandom_range(1, 24);
         else
            n = we + $urandom_range(0, 4);
         // occasional broken frames: restart mid-frame or no frame mark
         cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : -1;
         mark_first = ($urandom_range(0, 5) != 0);
         for (i = 0; i < n; i++)
            send_bin(rand_bin(), (i == 0 && mark_first) || i == cut);
         sent += n;
      end
      drain_packets();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      recv_idle_pct = 58;
      test_reset_defaults();
      test_window_and_groups();
      test_group_extremes();
      test_empty_window();
      test_partial_group();
      test_mid_frame_change();
      test_long_frame();
      test_backpressure();
      test_random_frames(12);

      send_idle_pct = 58;
      recv_idle_pct = 35;
      test_random_frames(12);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(12);

      drain_packets();
      if (errors == 0 && pkt_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/smd_pkg.sv
hw/rtl/smd_group.sv
hw/rtl/smd_serial.sv
hw/rtl/spectrum_max_decimator.sv
hw/rtl/smd_checker.sv
verif/spectrum_max_decimator_tb.sv
